// ===== rtl/rsgg_pkg.sv =====
// Shared constants, types and jump-ahead tables for the reference signal Gold generator.
package rsgg_pkg;

    localparam int LFSR_W            = 31;
    localparam int DISCARD_CHIPS     = 1600;
    localparam int SYMS_PER_GROUP    = 8;
    localparam int CHIPS_PER_GROUP   = 2 * SYMS_PER_GROUP;
    localparam int CINIT_SHIFT       = 10;
    localparam int DEF_MAX_RESOURCE_BLOCKS = 110;

    localparam int SLOT_W     = 5;
    localparam int SYMBOL_W   = 3;
    localparam int CELL_ID_W  = 9;
    localparam int CHIP_W     = 16;
    localparam int FIRST_W    = 8;
    localparam int COUNT_W    = 4;
    localparam int SUM_W      = 8;
    localparam int MULT_W     = CELL_ID_W + 1;
    localparam int PROD_W     = SUM_W + MULT_W;
    localparam int CINIT_W    = PROD_W + CINIT_SHIFT;

    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 32;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam logic REG_CELL_ID   = 1'b0;
    localparam logic REG_NORMAL_CP = 1'b1;

    typedef logic [LFSR_W-1:0] lfsr_t;
    typedef logic [LFSR_W-1:0][LFSR_W-1:0] jump_mat_t;

    function automatic lfsr_t x1_jump_state();
        lfsr_t s;
        logic  nb;
        s = lfsr_t'(1);
        for (int i = 0; i < DISCARD_CHIPS; i++)
        begin
            nb = s[0] ^ s[3];
            s  = {nb, s[LFSR_W-1:1]};
        end
        return s;
    endfunction

    function automatic jump_mat_t x2_jump_matrix();
        jump_mat_t m;
        lfsr_t     nb;
        for (int k = 0; k < LFSR_W; k++)
        begin
            m[k] = lfsr_t'(1) << k;
        end
        for (int i = 0; i < DISCARD_CHIPS; i++)
        begin
            nb = m[0] ^ m[1] ^ m[2] ^ m[3];
            for (int k = 0; k < LFSR_W - 1; k++)
            begin
                m[k] = m[k+1];
            end
            m[LFSR_W-1] = nb;
        end
        return m;
    endfunction

    localparam lfsr_t     X1_JUMP = x1_jump_state();
    localparam jump_mat_t X2_JUMP = x2_jump_matrix();

endpackage

// ===== rtl/reference_signal_gold_generator_core.sv =====
// Top level of the cell reference signal Gold sequence generator.
// Each request (slot number, symbol index) yields ceil(2*MAX_RESOURCE_BLOCKS/8) result
// transactions (28 at the default), one per cycle unless m_tready stalls the output, each
// carrying the QPSK sign bits of up to eight symbols (four in the last at the default); the
// last one is flagged on m_tlast. The generator is a row of 31 bit cells that advances the
// x1/x2 pair by 16 chips per transaction, and the next request can follow without a gap. The
// init value and the 1600-chip jump are computed in seed registers a and b ahead of the
// cells and overlap the previous request. cell_id sits at byte address 0, normal_cp at 4.
module reference_signal_gold_generator_core
#(
    parameter int MAX_RESOURCE_BLOCKS = rsgg_pkg::DEF_MAX_RESOURCE_BLOCKS
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rsgg_pkg::PADDR_W-1:0]      paddr,
    input  logic [rsgg_pkg::PDATA_W-1:0]      pwdata,
    output logic [rsgg_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [4:0] slot_num, [7:5] symbol_index
    input  logic [rsgg_pkg::IN_DATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [15:0] chip_bits, [23:16] first_symbol, [27:24] symbol_count, [31:28] zero
    output logic [rsgg_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic                              m_tlast
);
    import rsgg_pkg::*;

    localparam int TOTAL_SYMS = 2 * MAX_RESOURCE_BLOCKS;
    localparam int GROUPS     = (TOTAL_SYMS + SYMS_PER_GROUP - 1) / SYMS_PER_GROUP;
    localparam int GRP_W      = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int LAST_COUNT = TOTAL_SYMS - SYMS_PER_GROUP * (GROUPS - 1);
    localparam logic [CHIP_W-1:0] LAST_MASK =
        CHIP_W'((33'd1 << (2 * LAST_COUNT)) - 33'd1);
    localparam int STRIDE     = CHIPS_PER_GROUP;

    logic [CELL_ID_W-1:0] cell_id_reg;
    logic                 normal_cp_reg;
    logic                 cfg_write;

    logic                 seed_valid;
    logic                 seed_ready;
    lfsr_t                x2_seed;

    logic                 gen_busy_reg;
    logic                 gen_busy_next;
    logic [GRP_W-1:0]     grp_reg;
    logic [GRP_W-1:0]     grp_next;
    logic                 gen_fire;
    logic                 gen_load;
    logic                 last_grp;
    logic                 out_free;

    lfsr_t                x1;
    lfsr_t                x2;
    lfsr_t                nx1;
    lfsr_t                nx2;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [CHIP_W-1:0]    out_chips_reg;
    logic [FIRST_W-1:0]   out_first_reg;
    logic [COUNT_W-1:0]   out_count_reg;
    logic                 out_last_reg;
    logic [CHIP_W-1:0]    chips;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_id_reg   <= '0;
            normal_cp_reg <= 1'b1;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_CELL_ID:   cell_id_reg   <= pwdata[CELL_ID_W-1:0];
                REG_NORMAL_CP: normal_cp_reg <= pwdata[0];
                default:       cell_id_reg   <= cell_id_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_CELL_ID:   prdata = PDATA_W'(cell_id_reg);
            REG_NORMAL_CP: prdata = PDATA_W'(normal_cp_reg);
            default:       prdata = '0;
        endcase
    end

    rsgg_seed u_seed
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .slot_num     (s_tdata[SLOT_W-1:0]),
        .symbol_index (s_tdata[SLOT_W+SYMBOL_W-1:SLOT_W]),
        .cell_id      (cell_id_reg),
        .normal_cp    (normal_cp_reg),
        .out_valid    (seed_valid),
        .out_ready    (seed_ready),
        .x2_seed      (x2_seed)
    );

    assign out_free   = !out_valid_reg || m_tready;
    assign gen_fire   = gen_busy_reg && out_free;
    assign last_grp   = (grp_reg == GRP_W'(GROUPS - 1));
    assign gen_load   = seed_valid && (!gen_busy_reg || (gen_fire && last_grp));
    assign seed_ready = gen_load;

    for (genvar j = 0; j < LFSR_W; j++)
    begin : g_cells
        if (j < LFSR_W - STRIDE)
        begin : g_move
            assign nx1[j] = x1[j+STRIDE];
            assign nx2[j] = x2[j+STRIDE];
        end
        else
        begin : g_feed
            localparam int K = j - (LFSR_W - STRIDE);
            assign nx1[j] = x1[K] ^ x1[K+3];
            assign nx2[j] = x2[K] ^ x2[K+1] ^ x2[K+2] ^ x2[K+3];
        end

        rsgg_cell u_cell
        (
            .clk      (clk),
            .load     (gen_load),
            .load_x1  (X1_JUMP[j]),
            .load_x2  (x2_seed[j]),
            .shift_en (gen_fire),
            .next_x1  (nx1[j]),
            .next_x2  (nx2[j]),
            .x1       (x1[j]),
            .x2       (x2[j])
        );
    end

    always_comb
    begin
        gen_busy_next = gen_busy_reg;
        grp_next      = grp_reg;
        if (gen_load)
        begin
            gen_busy_next = 1'b1;
            grp_next      = '0;
        end
        else if (gen_fire)
        begin
            if (last_grp)
            begin
                gen_busy_next = 1'b0;
                grp_next      = '0;
            end
            else
            begin
                grp_next = grp_reg + GRP_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_busy_reg <= 1'b0;
            grp_reg      <= '0;
        end
        else
        begin
            gen_busy_reg <= gen_busy_next;
            grp_reg      <= grp_next;
        end
    end

    assign chips = x1[CHIP_W-1:0] ^ x2[CHIP_W-1:0];

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (gen_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (gen_fire)
        begin
            out_chips_reg <= last_grp ? (chips & LAST_MASK) : chips;
            out_first_reg <= FIRST_W'({grp_reg, 3'b000});
            out_count_reg <= last_grp ? COUNT_W'(LAST_COUNT) : COUNT_W'(SYMS_PER_GROUP);
            out_last_reg  <= last_grp;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'({out_count_reg, out_first_reg, out_chips_reg});
    assign m_tlast  = out_last_reg;

endmodule

// ===== rtl/rsgg_cell.sv =====
// One bit position of the x1/x2 shift register pair.
module rsgg_cell
(
    input  logic clk,
    input  logic load,
    input  logic load_x1,
    input  logic load_x2,
    input  logic shift_en,
    input  logic next_x1,
    input  logic next_x2,
    output logic x1,
    output logic x2
);

    logic x1_reg;
    logic x2_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            x1_reg <= load_x1;
            x2_reg <= load_x2;
        end
        else if (shift_en)
        begin
            x1_reg <= next_x1;
            x2_reg <= next_x2;
        end
    end

    assign x1 = x1_reg;
    assign x2 = x2_reg;

endmodule

// ===== rtl/rsgg_seed.sv =====
// Init value computation and x2 jump past the discarded chips.
module rsgg_seed
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [rsgg_pkg::SLOT_W-1:0]     slot_num,
    input  logic [rsgg_pkg::SYMBOL_W-1:0]   symbol_index,
    input  logic [rsgg_pkg::CELL_ID_W-1:0]  cell_id,
    input  logic                            normal_cp,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [rsgg_pkg::LFSR_W-1:0]     x2_seed
);
    import rsgg_pkg::*;

    logic               a_valid_reg;
    logic               a_valid_next;
    logic [PROD_W-1:0]  a_prod_reg;
    logic [CINIT_SHIFT-1:0] a_low_reg;
    logic               b_valid_reg;
    logic               b_valid_next;
    lfsr_t              b_x2_reg;
    logic               b_ready;
    logic               a_fire;
    logic               b_fire;
    logic [SUM_W-1:0]   sum;
    logic [MULT_W-1:0]  mult;
    logic [PROD_W-1:0]  prod;
    lfsr_t              cinit;
    lfsr_t              x2_jump;

    always_comb
    begin
        sum  = (SUM_W'(slot_num) << 3) - SUM_W'(slot_num)
             + SUM_W'(symbol_index) + SUM_W'(8);
        mult = {cell_id, 1'b1};
        prod = PROD_W'(sum) * PROD_W'(mult);
    end

    always_comb
    begin
        cinit = LFSR_W'({a_prod_reg, a_low_reg});
        for (int i = 0; i < LFSR_W; i++)
        begin
            x2_jump[i] = ^(X2_JUMP[i] & cinit);
        end
    end

    assign b_ready  = !b_valid_reg || out_ready;
    assign b_fire   = a_valid_reg && b_ready;
    assign in_ready = !a_valid_reg || b_ready;
    assign a_fire   = in_valid && in_ready;

    always_comb
    begin
        a_valid_next = a_valid_reg;
        b_valid_next = b_valid_reg;
        if (a_fire)
        begin
            a_valid_next = 1'b1;
        end
        else if (b_fire)
        begin
            a_valid_next = 1'b0;
        end
        if (b_fire)
        begin
            b_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            b_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_fire)
        begin
            a_prod_reg <= prod;
            a_low_reg  <= {cell_id, normal_cp};
        end
        if (b_fire)
        begin
            b_x2_reg <= x2_jump;
        end
    end

    assign out_valid = b_valid_reg;
    assign x2_seed   = b_x2_reg;

endmodule
